// ===== rtl/taus2_pkg.sv =====
// Shared constants and component recurrences for the taus2 generator.
// No dependencies; imported by tausworthe_taus2_generator.
`timescale 1ns / 1ps
package taus2_pkg;

    localparam int WORD_W    = 32;
    localparam int S_DATA_W  = 72;   // mode(2) + seed(32) + bound(32), padded to bytes
    localparam int M_DATA_W  = 32;
    localparam int MODE_W    = 2;
    localparam int LCG_BITS  = 17;   // 69069 fits in 17 bits
    localparam int CNT_W     = 5;
    localparam int WARM_DRAWS = 6;

    localparam logic [LCG_BITS-1:0] LCG_MULT = 17'd69069;

    localparam logic [MODE_W-1:0] MODE_SEED    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_RAW     = 2'd1;
    localparam logic [MODE_W-1:0] MODE_BOUNDED = 2'd2;
    localparam logic [MODE_W-1:0] MODE_UNUSED  = 2'd3;

    typedef logic [WORD_W-1:0] word_t;

    // Per-word floor applied after the LCG fill.
    function automatic word_t seed_floor(input logic [1:0] idx);
        word_t f;
        unique case (idx)
            2'd0:    f = 32'd2;
            2'd1:    f = 32'd8;
            default: f = 32'd16;
        endcase
        return f;
    endfunction

    function automatic word_t taus_one(input word_t s);
        return ((s & 32'hFFFF_FFFE) << 12) ^ (((s << 13) ^ s) >> 19);
    endfunction

    function automatic word_t taus_two(input word_t s);
        return ((s & 32'hFFFF_FFF8) << 4) ^ (((s << 2) ^ s) >> 25);
    endfunction

    function automatic word_t taus_three(input word_t s);
        return ((s & 32'hFFFF_FFF0) << 17) ^ (((s << 3) ^ s) >> 11);
    endfunction

endpackage

// ===== rtl/tausworthe_taus2_generator.sv =====
// Combined three-component Tausworthe (taus2) generator, top level.
// Depends on taus2_pkg for constants and the component recurrences.
`timescale 1ns / 1ps
// One transfer in gives one transfer out. Modes: seed (LCG fill from
// seed_value, floors, six warm-up draws, returns value 0), raw draw (XOR
// of the three stepped words), bounded draw (uniform integer below
// range_bound by rejection; a bound of zero returns status 1 and leaves the
// state alone), and the unused code 3, which returns 0 and touches nothing.
// Raw, unused and zero-bound transfers go straight to ST_DONE. Seeding
// runs the bit-serial shift-add LCG multiplier (17 multiplier bits per
// word); a bounded draw runs the shared one-bit-per-cycle restoring
// divider once for the scale floor((2^32-1)/n) and once per draw for the
// quotient, taking one or more draws. A new transfer is taken as soon as
// the core is back in idle, even while the previous result still waits in
// the output register. After reset the core seeds itself with zero, with
// s_tready low throughout, and emits no result.
module tausworthe_taus2_generator (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [taus2_pkg::S_DATA_W-1:0] s_tdata,   // [1:0] mode, [33:2] seed_value,
                                                      // [65:34] range_bound, rest zero
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [taus2_pkg::M_DATA_W-1:0] m_tdata,   // [31:0] value
    output logic                           m_tuser    // [0] status: 1 = zero bound
);
    import taus2_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_LCG   = 3'd1;   // shift-add LCG fill, one bit per cycle
    localparam logic [2:0] ST_WARM  = 3'd2;   // six discarded draws
    localparam logic [2:0] ST_SCALE = 3'd3;   // divider: (2^32-1) / n
    localparam logic [2:0] ST_DRAW  = 3'd4;   // step words, load draw into divider
    localparam logic [2:0] ST_DIVK  = 3'd5;   // divider: draw / scale
    localparam logic [2:0] ST_DONE  = 3'd6;   // hand result to output register

    logic [2:0]          state_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic [1:0]          idx_reg;
    logic                emit_reg;     // seeding came from a transfer (not reset)
    word_t               c1_reg, c2_reg, c3_reg;
    word_t               bound_reg, scale_reg;
    word_t               acc_reg, mcand_reg;
    logic [LCG_BITS-1:0] mult_reg;
    word_t               div_q_reg, div_r_reg, div_d_reg;
    word_t               res_value_reg;
    logic                res_status_reg;
    logic                m_valid_reg;
    word_t               m_value_reg;
    logic                m_status_reg;

    logic [MODE_W-1:0]   in_mode;
    word_t               in_seed, in_bound;
    word_t               n1, n2, n3, draw_val;
    word_t               acc_sum, lcg_word, lcg_floor, lcg_raised;
    logic [WORD_W:0]     r_sh;
    logic                div_ge;
    word_t               r_new, q_new;
    logic                out_free;

    assign in_mode  = s_tdata[MODE_W-1:0];
    assign in_seed  = s_tdata[MODE_W +: WORD_W];
    assign in_bound = s_tdata[MODE_W+WORD_W +: WORD_W];

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_value_reg;
    assign m_tuser  = m_status_reg;
    assign out_free = !m_valid_reg || m_tready;

    // One generator step of all three components.
    assign n1       = taus_one(c1_reg);
    assign n2       = taus_two(c2_reg);
    assign n3       = taus_three(c3_reg);
    assign draw_val = n1 ^ n2 ^ n3;

    // LCG: one multiplier bit per cycle, multiplicand shifts left.
    assign acc_sum    = acc_reg + (mult_reg[0] ? mcand_reg : '0);
    assign lcg_word   = acc_sum;
    assign lcg_floor  = seed_floor(idx_reg);
    assign lcg_raised = (lcg_word < lcg_floor) ? lcg_word + lcg_floor : lcg_word;

    // Restoring divider, one quotient bit per cycle.
    assign r_sh   = {div_r_reg, div_q_reg[WORD_W-1]};
    assign div_ge = (r_sh >= {1'b0, div_d_reg});
    assign r_new  = div_ge ? word_t'(r_sh - {1'b0, div_d_reg}) : r_sh[WORD_W-1:0];
    assign q_new  = {div_q_reg[WORD_W-2:0], div_ge};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_LCG;       // self-seed with zero
            cnt_reg     <= '0;
            idx_reg     <= '0;
            emit_reg    <= 1'b0;
            acc_reg     <= '0;
            mcand_reg   <= '0;
            mult_reg    <= LCG_MULT;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_valid_reg && m_tready) begin
                m_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        res_value_reg  <= '0;
                        res_status_reg <= 1'b0;
                        unique case (in_mode)
                            MODE_SEED: begin
                                mcand_reg <= in_seed;
                                acc_reg   <= '0;
                                mult_reg  <= LCG_MULT;
                                cnt_reg   <= '0;
                                idx_reg   <= '0;
                                emit_reg  <= 1'b1;
                                state_reg <= ST_LCG;
                            end
                            MODE_RAW: begin
                                c1_reg        <= n1;
                                c2_reg        <= n2;
                                c3_reg        <= n3;
                                res_value_reg <= draw_val;
                                state_reg     <= ST_DONE;
                            end
                            MODE_BOUNDED: begin
                                if (in_bound == '0) begin
                                    res_status_reg <= 1'b1;
                                    state_reg      <= ST_DONE;
                                end else begin
                                    bound_reg <= in_bound;
                                    div_q_reg <= '1;
                                    div_r_reg <= '0;
                                    div_d_reg <= in_bound;
                                    cnt_reg   <= '0;
                                    state_reg <= ST_SCALE;
                                end
                            end
                            MODE_UNUSED: begin
                                state_reg <= ST_DONE;
                            end
                        endcase
                    end
                end

                ST_LCG: begin
                    acc_reg   <= acc_sum;
                    mcand_reg <= mcand_reg << 1;
                    mult_reg  <= mult_reg >> 1;
                    cnt_reg   <= cnt_reg + 1'b1;
                    if (cnt_reg == CNT_W'(LCG_BITS - 1)) begin
                        unique case (idx_reg)
                            2'd0:    c1_reg <= lcg_raised;
                            2'd1:    c2_reg <= lcg_raised;
                            default: c3_reg <= lcg_raised;
                        endcase
                        acc_reg   <= '0;
                        mcand_reg <= lcg_raised;   // chain into next word
                        mult_reg  <= LCG_MULT;
                        cnt_reg   <= '0;
                        if (idx_reg == 2'd2) begin
                            state_reg <= ST_WARM;
                        end else begin
                            idx_reg <= idx_reg + 1'b1;
                        end
                    end
                end

                ST_WARM: begin
                    c1_reg  <= n1;
                    c2_reg  <= n2;
                    c3_reg  <= n3;
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == CNT_W'(WARM_DRAWS - 1)) begin
                        state_reg <= emit_reg ? ST_DONE : ST_IDLE;
                    end
                end

                ST_SCALE: begin
                    div_q_reg <= q_new;
                    div_r_reg <= r_new;
                    cnt_reg   <= cnt_reg + 1'b1;
                    if (cnt_reg == CNT_W'(WORD_W - 1)) begin
                        scale_reg <= q_new;
                        state_reg <= ST_DRAW;
                    end
                end

                ST_DRAW: begin
                    c1_reg    <= n1;
                    c2_reg    <= n2;
                    c3_reg    <= n3;
                    div_q_reg <= draw_val;
                    div_r_reg <= '0;
                    div_d_reg <= scale_reg;
                    cnt_reg   <= '0;
                    state_reg <= ST_DIVK;
                end

                ST_DIVK: begin
                    div_q_reg <= q_new;
                    div_r_reg <= r_new;
                    cnt_reg   <= cnt_reg + 1'b1;
                    if (cnt_reg == CNT_W'(WORD_W - 1)) begin
                        if (q_new < bound_reg) begin
                            res_value_reg <= q_new;
                            state_reg     <= ST_DONE;
                        end else begin
                            state_reg <= ST_DRAW;   // reject, draw again
                        end
                    end
                end

                ST_DONE: begin
                    if (out_free) begin
                        m_valid_reg  <= 1'b1;
                        m_value_reg  <= res_value_reg;
                        m_status_reg <= res_status_reg;
                        emit_reg     <= 1'b0;
                        state_reg    <= ST_IDLE;
                    end
                end

                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule
